// ===== rtl/fpa_pkg.sv =====
package fpa_pkg;

  localparam int FRAC_BITS = 8;
  localparam int DW        = 32;
  localparam int NUM_DIGIT = DW + FRAC_BITS;  // quotient bits developed
  localparam int QW        = NUM_DIGIT;
  localparam int MW        = DW;               // magnitude of divisor

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
    OP_LT  = 4'd4, OP_LE  = 4'd5, OP_GT  = 4'd6, OP_GE  = 4'd7,
    OP_EQ  = 4'd8, OP_NE  = 4'd9, OP_MIN = 4'd10, OP_MAX = 4'd11,
    OP_INC = 4'd12, OP_DEC = 4'd13, OP_FINT = 4'd14, OP_TINT = 4'd15
  } op_t;

  // payload carried along the divider chain
  typedef struct packed {
    logic            vld;
    logic            is_div;
    logic            neg;        // quotient sign
    logic            dz;
    logic [QW-1:0]   num;        // dividend bits, shifted out MSB first
    logic [MW-1:0]   den;        // divisor magnitude
    logic [MW:0]     rem;        // partial remainder
    logic [QW-1:0]   quo;        // quotient bits, shifted in
    logic [DW-1:0]   res;        // non-divide result
    logic            cmp;
  } cell_t;

endpackage

// ===== rtl/fpa_cell.sv =====
module fpa_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  fpa_pkg::cell_t d_in,
  output fpa_pkg::cell_t d_out
);
  import fpa_pkg::*;

  cell_t         d_out_r, d_out_nxt;
  logic [MW:0]   trial;
  logic [MW+1:0] diff;

  // one restoring-division step per cell
  always_comb begin
    d_out_nxt = d_in;
    trial = {d_in.rem[MW-1:0], d_in.num[QW-1]};
    diff  = {1'b0, trial} - {2'b00, d_in.den};
    d_out_nxt.num = {d_in.num[QW-2:0], 1'b0};
    if (!diff[MW+1]) begin
      d_out_nxt.rem = diff[MW:0];
      d_out_nxt.quo = {d_in.quo[QW-2:0], 1'b1};
    end else begin
      d_out_nxt.rem = trial;
      d_out_nxt.quo = {d_in.quo[QW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_out_r.vld <= 1'b0;
    end else if (en) begin
      d_out_r <= d_out_nxt;
    end
  end

  assign d_out = d_out_r;
endmodule

// ===== rtl/fpa_front.sv =====
module fpa_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  vld,
  input  logic [3:0]            opcode,
  input  logic signed [fpa_pkg::DW-1:0] operand_a,
  input  logic signed [fpa_pkg::DW-1:0] operand_b,
  output fpa_pkg::cell_t        d_out
);
  import fpa_pkg::*;

  cell_t                 d_r, d_nxt;
  logic signed [2*DW-1:0] prod;
  logic [2*DW-1:0]       prod_sh;
  logic [DW-1:0]         ma, mb;

  // multiply is the one wide product here; registered before leaving
  always_comb begin
    prod    = operand_a * operand_b;
    prod_sh = 64'(prod >>> FRAC_BITS);
    ma = operand_a[DW-1] ? DW'(-operand_a) : operand_a;
    mb = operand_b[DW-1] ? DW'(-operand_b) : operand_b;
    d_nxt        = '0;
    d_nxt.vld    = vld;
    d_nxt.den    = mb;
    d_nxt.num    = {ma, {FRAC_BITS{1'b0}}};
    d_nxt.neg    = operand_a[DW-1] ^ operand_b[DW-1];
    case (op_t'(opcode))
      OP_ADD:  d_nxt.res = operand_a + operand_b;
      OP_SUB:  d_nxt.res = operand_a - operand_b;
      OP_MUL:  d_nxt.res = prod_sh[DW-1:0];
      OP_DIV: begin
        d_nxt.is_div = (operand_b != '0);
        d_nxt.dz     = (operand_b == '0);
      end
      OP_LT:   d_nxt.cmp = operand_a <  operand_b;
      OP_LE:   d_nxt.cmp = operand_a <= operand_b;
      OP_GT:   d_nxt.cmp = operand_a >  operand_b;
      OP_GE:   d_nxt.cmp = operand_a >= operand_b;
      OP_EQ:   d_nxt.cmp = operand_a == operand_b;
      OP_NE:   d_nxt.cmp = operand_a != operand_b;
      OP_MIN:  d_nxt.res = (operand_a < operand_b) ? operand_a : operand_b;
      OP_MAX:  d_nxt.res = (operand_a > operand_b) ? operand_a : operand_b;
      OP_INC:  d_nxt.res = operand_a + DW'(1);
      OP_DEC:  d_nxt.res = operand_a - DW'(1);
      OP_FINT: d_nxt.res = operand_a << FRAC_BITS;
      OP_TINT: d_nxt.res = operand_a >>> FRAC_BITS;
      default: d_nxt.res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.vld <= 1'b0;
    end else if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_out = d_r;
endmodule

// ===== rtl/fixed_point_alu_q24_8_unit.sv =====
// Channel | Ports            | tdata fields (low bit up)
// input   | in_t*            | opcode[3:0], operand_a[35:4], operand_b[67:36], zero fill
// result  | out_t*           | result_raw[31:0], compare_true[32], divide_by_zero[33], fill
// One item enters per cycle while the output is not stalled; the pipeline is the front
// register plus the chain of restoring-division cells, one quotient bit per cell.
// Every op travels the same chain, so results leave in order.
// Reset (rst_n low, synchronous) clears the valid bits of all stages.
// A stall at the output freezes the whole chain; the input then stops too.
module fixed_point_alu_q24_8_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // opcode, operand_a, operand_b
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // result_raw, compare_true, divide_by_zero
);
  import fpa_pkg::*;

  cell_t chain [NUM_DIGIT+1];
  logic  en;
  cell_t last;
  logic [DW-1:0] quo32, res_fin;

  // freeze when the tail holds a result not yet taken
  assign en        = !chain[NUM_DIGIT].vld || out_tready;
  assign in_tready = en;

  fpa_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .vld       (in_tvalid),
    .opcode    (in_tdata[3:0]),
    .operand_a (in_tdata[35:4]),
    .operand_b (in_tdata[67:36]),
    .d_out     (chain[0])
  );

  for (genvar i = 0; i < NUM_DIGIT; i++) begin : g_cell
    fpa_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d_in  (chain[i]),
      .d_out (chain[i+1])
    );
  end

  assign last  = chain[NUM_DIGIT];
  assign quo32 = last.neg ? DW'(-last.quo[DW-1:0]) : last.quo[DW-1:0];
  assign res_fin = last.is_div ? quo32 : (last.dz ? '0 : last.res);

  assign out_tvalid = last.vld;
  assign out_tdata  = {6'b0, last.dz, last.cmp, res_fin};
endmodule
